@@ hdl/hwck_pkg.sv @@
// Shared types and constants for the hue window chroma key.
// No dependencies; every other file in this folder imports it.
package hwck_pkg;

   // Number of quotient bits produced by the divider chain, one per cell.
   localparam int unsigned QUO_W      = 12;
   localparam int unsigned CHAN_OUT_W = 8;
   localparam int unsigned HUE_W      = 15;

   localparam logic [11:0] HUE_SIXTH  = 12'd3840;
   localparam logic [14:0] HUE_TURN   = 15'd23040;
   localparam logic [7:0]  KEY_OPAQUE = 8'hFF;
   localparam logic [7:0]  SAT_SCALE  = 8'd255;

   typedef enum logic [0:0] {
      CSR_HUE_LOW  = 1'b0,
      CSR_HUE_HIGH = 1'b1
   } hwck_csr_type;

   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } hwck_sector_type;

   // Per-pixel information that rides alongside the divider lanes.
   typedef struct packed {
      logic [CHAN_OUT_W-1:0] red;
      logic [CHAN_OUT_W-1:0] green;
      logic [CHAN_OUT_W-1:0] blue;
      logic [CHAN_OUT_W-1:0] max_chan;
      hwck_sector_type       sector;
      logic                  diff_neg;
      logic                  undef;
   } hwck_side_type;

endpackage

@@ hdl/hwck_prep.sv @@
// Front stage: max/min search, sector choice and divider operand set-up.
// Depends on hwck_pkg.
module hwck_prep import hwck_pkg::*; #(
   parameter int unsigned CHAN_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  logic [CHAN_OUT_W-1:0]   up_red,
   input  logic [CHAN_OUT_W-1:0]   up_green,
   input  logic [CHAN_OUT_W-1:0]   up_blue,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output hwck_side_type           dn_side,
   output logic [CHAN_W+QUO_W-1:0] dn_hue_rem,
   output logic [CHAN_W+QUO_W-1:0] dn_hue_dsh,
   output logic [CHAN_W+QUO_W-1:0] dn_sat_rem,
   output logic [CHAN_W+QUO_W-1:0] dn_sat_dsh
);

   localparam int unsigned NW = CHAN_W + QUO_W;

   logic                valid_ff;
   hwck_side_type       side_ff, side_in;
   logic [NW-1:0]       hue_rem_ff, hue_rem_in;
   logic [NW-1:0]       hue_dsh_ff, hue_dsh_in;
   logic [NW-1:0]       sat_rem_ff, sat_rem_in;
   logic [NW-1:0]       sat_dsh_ff, sat_dsh_in;

   always_comb begin
      logic [CHAN_W-1:0] r, g, b, mx, mn, delta, mag;
      r = up_red[CHAN_W-1:0];
      g = up_green[CHAN_W-1:0];
      b = up_blue[CHAN_W-1:0];
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;

      side_in.red      = CHAN_OUT_W'(r);
      side_in.green    = CHAN_OUT_W'(g);
      side_in.blue     = CHAN_OUT_W'(b);
      side_in.max_chan = CHAN_OUT_W'(mx);
      side_in.undef    = (delta == '0);

      // Red wins ties, then green.
      if (r == mx) begin
         side_in.sector   = SECT_RED;
         side_in.diff_neg = (g < b);
         mag              = (g < b) ? (b - g) : (g - b);
      end else if (g == mx) begin
         side_in.sector   = SECT_GREEN;
         side_in.diff_neg = (b < r);
         mag              = (b < r) ? (r - b) : (b - r);
      end else begin
         side_in.sector   = SECT_BLUE;
         side_in.diff_neg = (r < g);
         mag              = (r < g) ? (g - r) : (r - g);
      end

      hue_rem_in = NW'(mag) * NW'(HUE_SIXTH);
      hue_dsh_in = NW'(delta) << (QUO_W - 1);
      sat_rem_in = NW'(delta) * NW'(SAT_SCALE);
      sat_dsh_in = NW'(mx) << (QUO_W - 1);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         side_ff    <= side_in;
         hue_rem_ff <= hue_rem_in;
         hue_dsh_ff <= hue_dsh_in;
         sat_rem_ff <= sat_rem_in;
         sat_dsh_ff <= sat_dsh_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_side    = side_ff;
   assign dn_hue_rem = hue_rem_ff;
   assign dn_hue_dsh = hue_dsh_ff;
   assign dn_sat_rem = sat_rem_ff;
   assign dn_sat_dsh = sat_dsh_ff;

endmodule

@@ hdl/hwck_div_cell.sv @@
// One restoring-division step for the hue and saturation lanes, registered.
// Depends on hwck_pkg; instanced as a chain of QUO_W cells by the top level.
module hwck_div_cell import hwck_pkg::*; #(
   parameter int unsigned CHAN_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  hwck_side_type           up_side,
   input  logic [CHAN_W+QUO_W-1:0] up_hue_rem,
   input  logic [CHAN_W+QUO_W-1:0] up_hue_dsh,
   input  logic [QUO_W-1:0]        up_hue_quo,
   input  logic [CHAN_W+QUO_W-1:0] up_sat_rem,
   input  logic [CHAN_W+QUO_W-1:0] up_sat_dsh,
   input  logic [QUO_W-1:0]        up_sat_quo,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output hwck_side_type           dn_side,
   output logic [CHAN_W+QUO_W-1:0] dn_hue_rem,
   output logic [CHAN_W+QUO_W-1:0] dn_hue_dsh,
   output logic [QUO_W-1:0]        dn_hue_quo,
   output logic [CHAN_W+QUO_W-1:0] dn_sat_rem,
   output logic [CHAN_W+QUO_W-1:0] dn_sat_dsh,
   output logic [QUO_W-1:0]        dn_sat_quo
);

   localparam int unsigned NW = CHAN_W + QUO_W;

   logic             valid_ff;
   hwck_side_type    side_ff;
   logic [NW-1:0]    hue_rem_ff, hue_rem_in, hue_dsh_ff;
   logic [NW-1:0]    sat_rem_ff, sat_rem_in, sat_dsh_ff;
   logic [QUO_W-1:0] hue_quo_ff, hue_quo_in, sat_quo_ff, sat_quo_in;
   logic             hue_take, sat_take;

   // The shifted divisor halves from cell to cell, so every cell is alike.
   assign hue_take   = (up_hue_rem >= up_hue_dsh);
   assign sat_take   = (up_sat_rem >= up_sat_dsh);
   assign hue_rem_in = hue_take ? (up_hue_rem - up_hue_dsh) : up_hue_rem;
   assign sat_rem_in = sat_take ? (up_sat_rem - up_sat_dsh) : up_sat_rem;
   assign hue_quo_in = {up_hue_quo[QUO_W-2:0], hue_take};
   assign sat_quo_in = {up_sat_quo[QUO_W-2:0], sat_take};

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         side_ff    <= up_side;
         hue_rem_ff <= hue_rem_in;
         hue_dsh_ff <= up_hue_dsh >> 1;
         hue_quo_ff <= hue_quo_in;
         sat_rem_ff <= sat_rem_in;
         sat_dsh_ff <= up_sat_dsh >> 1;
         sat_quo_ff <= sat_quo_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_side    = side_ff;
   assign dn_hue_rem = hue_rem_ff;
   assign dn_hue_dsh = hue_dsh_ff;
   assign dn_hue_quo = hue_quo_ff;
   assign dn_sat_rem = sat_rem_ff;
   assign dn_sat_dsh = sat_dsh_ff;
   assign dn_sat_quo = sat_quo_ff;

endmodule

@@ hdl/hwck_post.sv @@
// Output stage: hue assembly, wrap, window compare and the result register.
// Depends on hwck_pkg.
module hwck_post import hwck_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [HUE_W-1:0]      hue_low,
   input  logic [HUE_W-1:0]      hue_high,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  hwck_side_type         up_side,
   input  logic [QUO_W-1:0]      up_hue_quo,
   input  logic [QUO_W-1:0]      up_sat_quo,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_OUT_W-1:0] rsp_out_red,
   output logic [CHAN_OUT_W-1:0] rsp_out_green,
   output logic [CHAN_OUT_W-1:0] rsp_out_blue,
   output logic [CHAN_OUT_W-1:0] rsp_alpha,
   output logic [HUE_W-1:0]      rsp_hue,
   output logic                  rsp_hue_undefined,
   output logic [CHAN_OUT_W-1:0] rsp_saturation,
   output logic [CHAN_OUT_W-1:0] rsp_brightness
);

   logic                  valid_ff;
   logic [CHAN_OUT_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [CHAN_OUT_W-1:0] alpha_ff, alpha_in, sat_ff, sat_in, bright_ff;
   logic [HUE_W-1:0]      hue_ff, hue_in;
   logic                  undef_ff;

   always_comb begin
      logic signed [16:0] base;
      logic signed [16:0] quo;
      logic signed [16:0] sum;
      logic               keyed;
      case (up_side.sector)
         SECT_RED:   base = 17'sd0;
         SECT_GREEN: base = $signed(17'({HUE_SIXTH, 1'b0}));
         default:    base = $signed(17'({HUE_SIXTH, 2'b00}));
      endcase
      quo = $signed(17'(up_hue_quo));
      sum = up_side.diff_neg ? (base - quo) : (base + quo);
      if (sum < 0) begin
         sum = sum + $signed(17'(HUE_TURN));
      end
      hue_in = up_side.undef ? '0 : sum[HUE_W-1:0];
      keyed  = !up_side.undef && (hue_in > hue_low) && (hue_in < hue_high);

      red_in   = keyed ? '0 : up_side.red;
      green_in = keyed ? '0 : up_side.green;
      blue_in  = keyed ? '0 : up_side.blue;
      alpha_in = keyed ? '0 : KEY_OPAQUE;
      // A black pixel divides by zero; its saturation is defined as zero.
      sat_in   = (up_side.max_chan == '0) ? '0 : up_sat_quo[CHAN_OUT_W-1:0];
   end

   assign up_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         alpha_ff  <= alpha_in;
         hue_ff    <= hue_in;
         undef_ff  <= up_side.undef;
         sat_ff    <= sat_in;
         bright_ff <= up_side.max_chan;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_red       = red_ff;
   assign rsp_out_green     = green_ff;
   assign rsp_out_blue      = blue_ff;
   assign rsp_alpha         = alpha_ff;
   assign rsp_hue           = hue_ff;
   assign rsp_hue_undefined = undef_ff;
   assign rsp_saturation    = sat_ff;
   assign rsp_brightness    = bright_ff;

endmodule

@@ hdl/hue_window_chroma_key.sv @@
// Pipeline: a word accepted on the request port reaches the result port through
// one set-up stage, a chain of 12 divider cells and one output register.
// Throughput: one pixel per clock while rsp_ready stays high; a low rsp_ready backs up the chain.
// Each stage holds its word only while the next is full, so bubbles are squeezed out.
// Reset is synchronous: all stages empty, hue bounds return to 18560 and 22400.
// Depends on hwck_pkg, hwck_prep, hwck_div_cell and hwck_post.
module hue_window_chroma_key import hwck_pkg::*; #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  hwck_csr_type          csr_index,
   input  logic [HUE_W-1:0]      csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAN_OUT_W-1:0] req_red,
   input  logic [CHAN_OUT_W-1:0] req_green,
   input  logic [CHAN_OUT_W-1:0] req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAN_OUT_W-1:0] rsp_out_red,
   output logic [CHAN_OUT_W-1:0] rsp_out_green,
   output logic [CHAN_OUT_W-1:0] rsp_out_blue,
   output logic [CHAN_OUT_W-1:0] rsp_alpha,
   output logic [HUE_W-1:0]      rsp_hue,
   output logic                  rsp_hue_undefined,
   output logic [CHAN_OUT_W-1:0] rsp_saturation,
   output logic [CHAN_OUT_W-1:0] rsp_brightness
);

   // The input ports are eight bits wide, so no more than eight bits can matter.
   localparam int unsigned CW = (CHANNEL_BITS < CHAN_OUT_W) ? CHANNEL_BITS : CHAN_OUT_W;
   localparam int unsigned NW = CW + QUO_W;

   logic [HUE_W-1:0] hue_low_ff, hue_high_ff;

   logic             stg_valid [QUO_W+1];
   logic             stg_ready [QUO_W+1];
   hwck_side_type    stg_side  [QUO_W+1];
   logic [NW-1:0]    stg_hrem  [QUO_W+1];
   logic [NW-1:0]    stg_hdsh  [QUO_W+1];
   logic [QUO_W-1:0] stg_hquo  [QUO_W+1];
   logic [NW-1:0]    stg_srem  [QUO_W+1];
   logic [NW-1:0]    stg_sdsh  [QUO_W+1];
   logic [QUO_W-1:0] stg_squo  [QUO_W+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= 15'd18560;
         hue_high_ff <= 15'd22400;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HUE_LOW:  hue_low_ff  <= csr_wdata;
            CSR_HUE_HIGH: hue_high_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   hwck_prep #(.CHAN_W(CW)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .up_red     (req_red),
      .up_green   (req_green),
      .up_blue    (req_blue),
      .dn_valid   (stg_valid[0]),
      .dn_ready   (stg_ready[0]),
      .dn_side    (stg_side[0]),
      .dn_hue_rem (stg_hrem[0]),
      .dn_hue_dsh (stg_hdsh[0]),
      .dn_sat_rem (stg_srem[0]),
      .dn_sat_dsh (stg_sdsh[0])
   );

   assign stg_hquo[0] = '0;
   assign stg_squo[0] = '0;

   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      hwck_div_cell #(.CHAN_W(CW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (stg_valid[i]),
         .up_ready   (stg_ready[i]),
         .up_side    (stg_side[i]),
         .up_hue_rem (stg_hrem[i]),
         .up_hue_dsh (stg_hdsh[i]),
         .up_hue_quo (stg_hquo[i]),
         .up_sat_rem (stg_srem[i]),
         .up_sat_dsh (stg_sdsh[i]),
         .up_sat_quo (stg_squo[i]),
         .dn_valid   (stg_valid[i+1]),
         .dn_ready   (stg_ready[i+1]),
         .dn_side    (stg_side[i+1]),
         .dn_hue_rem (stg_hrem[i+1]),
         .dn_hue_dsh (stg_hdsh[i+1]),
         .dn_hue_quo (stg_hquo[i+1]),
         .dn_sat_rem (stg_srem[i+1]),
         .dn_sat_dsh (stg_sdsh[i+1]),
         .dn_sat_quo (stg_squo[i+1])
      );
   end

   hwck_post u_post (
      .clock             (clock),
      .reset             (reset),
      .hue_low           (hue_low_ff),
      .hue_high          (hue_high_ff),
      .up_valid          (stg_valid[QUO_W]),
      .up_ready          (stg_ready[QUO_W]),
      .up_side           (stg_side[QUO_W]),
      .up_hue_quo        (stg_hquo[QUO_W]),
      .up_sat_quo        (stg_squo[QUO_W]),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_hue           (rsp_hue),
      .rsp_hue_undefined (rsp_hue_undefined),
      .rsp_saturation    (rsp_saturation),
      .rsp_brightness    (rsp_brightness)
   );

   // An accepted word must land in the set-up stage on the next edge.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stg_valid[0])
      else $error("accepted pixel did not enter the set-up stage");

   // A keyed pixel always has a defined hue inside the window.
   a_keyed_defined: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_alpha == '0) |->
         !rsp_hue_undefined && (rsp_hue > hue_low_ff) && (rsp_hue < hue_high_ff))
      else $error("keyed pixel with undefined or out-of-window hue");

   // Grey and black pixels report zero hue and zero saturation.
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hue_undefined |-> (rsp_hue == '0) && (rsp_saturation == '0))
      else $error("undefined hue with non-zero hue or saturation");

   // The hue wrap keeps every result below a full turn.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue < HUE_TURN))
      else $error("hue out of range");

endmodule

@@ dv/hwck_checker.sv @@
// Scoreboard for the hue window chroma key: it watches the register, pixel and result channels,
// predicts each result word from its own copy of the hue bounds and compares field by field.
// Depends on hwck_pkg for the register index type and the hue constants.
module hwck_checker import hwck_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  hwck_csr_type          csr_index,
   input  logic [HUE_W-1:0]      csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CHAN_OUT_W-1:0] req_red,
   input  logic [CHAN_OUT_W-1:0] req_green,
   input  logic [CHAN_OUT_W-1:0] req_blue,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CHAN_OUT_W-1:0] rsp_out_red,
   input  logic [CHAN_OUT_W-1:0] rsp_out_green,
   input  logic [CHAN_OUT_W-1:0] rsp_out_blue,
   input  logic [CHAN_OUT_W-1:0] rsp_alpha,
   input  logic [HUE_W-1:0]      rsp_hue,
   input  logic                  rsp_hue_undefined,
   input  logic [CHAN_OUT_W-1:0] rsp_saturation,
   input  logic [CHAN_OUT_W-1:0] rsp_brightness,
   output int                    fail_count,
   output int                    pending_count,
   output int                    keyed_count,
   output int                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [HUE_W-1:0] LOW_AT_RESET  = 15'd18560;
   localparam logic [HUE_W-1:0] HIGH_AT_RESET = 15'd22400;
   localparam int               SHOWN_LIMIT   = 10;

   typedef struct packed {
      logic [CHAN_OUT_W-1:0] red;
      logic [CHAN_OUT_W-1:0] green;
      logic [CHAN_OUT_W-1:0] blue;
      logic [CHAN_OUT_W-1:0] alpha;
      logic [HUE_W-1:0]      hue;
      logic                  undef;
      logic [CHAN_OUT_W-1:0] sat;
      logic [CHAN_OUT_W-1:0] bright;
   } keyed_pixel_type;

   keyed_pixel_type  awaited_pixels[$];
   logic [HUE_W-1:0] low_bound  = LOW_AT_RESET;
   logic [HUE_W-1:0] high_bound = HIGH_AT_RESET;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      keyed_count   = 0;
      checked_count = 0;
   end

   function automatic keyed_pixel_type key_pixel(logic [CHAN_OUT_W-1:0] r,
                                                 logic [CHAN_OUT_W-1:0] g,
                                                 logic [CHAN_OUT_W-1:0] b,
                                                 logic [HUE_W-1:0] lo,
                                                 logic [HUE_W-1:0] hi);
      int              ri, gi, bi, top, bottom, delta, base, diff, hue_i, sat_i, sixth, turn;
      logic            keyed;
      keyed_pixel_type res;
      ri     = int'(r);
      gi     = int'(g);
      bi     = int'(b);
      sixth  = int'(HUE_SIXTH);
      turn   = int'(HUE_TURN);
      top    = ri;
      bottom = ri;
      if (gi > top) top = gi;
      if (bi > top) top = bi;
      if (gi < bottom) bottom = gi;
      if (bi < bottom) bottom = bi;
      delta  = top - bottom;
      sat_i  = (top != 0) ? (delta * int'(SAT_SCALE)) / top : 0;
      hue_i  = 0;
      keyed  = 1'b0;
      // Red wins a tie for the maximum, then green.
      if (delta != 0) begin
         if (ri == top) begin
            base = 0;
            diff = gi - bi;
         end else if (gi == top) begin
            base = 2 * sixth;
            diff = bi - ri;
         end else begin
            base = 4 * sixth;
            diff = ri - gi;
         end
         hue_i = base + (diff * sixth) / delta;
         if (hue_i < 0) hue_i += turn;
         keyed = (hue_i > int'(lo)) && (hue_i < int'(hi));
      end
      res.red    = keyed ? '0 : r;
      res.green  = keyed ? '0 : g;
      res.blue   = keyed ? '0 : b;
      res.alpha  = keyed ? '0 : KEY_OPAQUE;
      res.hue    = hue_i[HUE_W-1:0];
      res.undef  = (delta == 0);
      res.sat    = sat_i[CHAN_OUT_W-1:0];
      res.bright = top[CHAN_OUT_W-1:0];
      return res;
   endfunction

   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= SHOWN_LIMIT)
            $display("%0t: %s mismatch on result word %0d: expected %0d, got %0d",
                     $realtime, field, checked_count, want, got);
      end
   endtask

   task automatic check_result();
      keyed_pixel_type want;
      if (awaited_pixels.size() == 0) begin
         fail_count++;
         if (fail_count <= SHOWN_LIMIT)
            $display("%0t: result word with no pixel awaiting it (hue %0d, alpha %0d)",
                     $realtime, rsp_hue, rsp_alpha);
      end else begin
         want = awaited_pixels.pop_front();
         compare_field("out_red",       want.red,    rsp_out_red);
         compare_field("out_green",     want.green,  rsp_out_green);
         compare_field("out_blue",      want.blue,   rsp_out_blue);
         compare_field("alpha",         want.alpha,  rsp_alpha);
         compare_field("hue",           want.hue,    rsp_hue);
         compare_field("hue_undefined", want.undef,  rsp_hue_undefined);
         compare_field("saturation",    want.sat,    rsp_saturation);
         compare_field("brightness",    want.bright, rsp_brightness);
         checked_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         low_bound  = LOW_AT_RESET;
         high_bound = HIGH_AT_RESET;
         awaited_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) begin
            awaited_pixels.push_back(key_pixel(req_red, req_green, req_blue,
                                               low_bound, high_bound));
            if (awaited_pixels[$].alpha == '0) keyed_count++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HUE_LOW: begin
                  low_bound = csr_wdata;
               end
               CSR_HUE_HIGH: begin
                  high_bound = csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = awaited_pixels.size();
   end

endmodule

@@ dv/hue_window_chroma_key_test.sv @@
// Top of the hue window chroma key testbench: clock, reset, pixel and register stimulus, verdict.
// Depends on hwck_pkg, the block hue_window_chroma_key and the scoreboard hwck_checker.
module hue_window_chroma_key_test import hwck_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIXELS_PER_SETTING = 145;
   localparam int SETTING_COUNT      = 12;
   localparam int DRAIN_CYCLES       = 24;

   // Primaries, ties for the maximum, black, white, gray, negative hue wrap, tiny deltas
   // and alternating bit patterns.
   localparam logic [23:0] OPENING_PIXELS [20] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'h010000, 24'h000100,
      24'h000001, 24'h010001, 24'h010100, 24'hFFFE00, 24'hAA55FF, 24'h55AA00,
      24'hFE00FF, 24'h7F807F
   };

   // Pixels whose hues sit exactly on the bounds 19200 and 23025, or just inside them.
   localparam logic [23:0] BOUND_PIXELS [4] = '{
      24'hFF00FF, 24'hFF0001, 24'hFF00FE, 24'hFF0002
   };

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   hwck_csr_type          csr_index         = CSR_HUE_LOW;
   logic [HUE_W-1:0]      csr_wdata         = '0;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [CHAN_OUT_W-1:0] req_red           = '0;
   logic [CHAN_OUT_W-1:0] req_green         = '0;
   logic [CHAN_OUT_W-1:0] req_blue          = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [CHAN_OUT_W-1:0] rsp_out_red;
   logic [CHAN_OUT_W-1:0] rsp_out_green;
   logic [CHAN_OUT_W-1:0] rsp_out_blue;
   logic [CHAN_OUT_W-1:0] rsp_alpha;
   logic [HUE_W-1:0]      rsp_hue;
   logic                  rsp_hue_undefined;
   logic [CHAN_OUT_W-1:0] rsp_saturation;
   logic [CHAN_OUT_W-1:0] rsp_brightness;

   int   fail_count;
   int   pending_count;
   int   keyed_count;
   int   checked_count;
   int   pixels_sent = 0;
   logic calm        = 1'b0;

   hue_window_chroma_key uut (.*);

   hwck_checker scoreboard (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic logic [23:0] random_pixel();
      logic [7:0] r, g, b;
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: begin
            g = r;
            b = r;
         end
         1: begin
            // Two channels are made equal; they tie for the maximum only if the third is not larger.
            case ($urandom_range(0, 2))
               0: g = r;
               1: b = g;
               default: r = b;
            endcase
         end
         2: begin
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            b = 8'($urandom_range(0, 3));
         end
         3: begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: begin
         end
      endcase
      return {r, g, b};
   endfunction

   // Entered and left at a falling edge; valid stays high between back-to-back words.
   task automatic send_pixel(logic [23:0] px);
      if (!calm && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_red, req_green, req_blue} <= px;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
   endtask

   // Both bounds in one burst, with valid held high between the two words.
   task automatic write_bounds(logic [HUE_W-1:0] lo, logic [HUE_W-1:0] hi);
      csr_valid <= 1'b1;
      csr_index <= CSR_HUE_LOW;
      csr_wdata <= lo;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_HUE_HIGH;
      csr_wdata <= hi;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : result_stalls
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (calm) begin
            stall = 0;
         end else if (stall == 0 && $urandom_range(0, 99) < 12) begin
            stall = idle_length();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [HUE_W-1:0] lo, hi;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Opening pixels against the bounds left by reset.
      foreach (OPENING_PIXELS[i]) send_pixel(OPENING_PIXELS[i]);
      req_valid <= 1'b0;
      drain();

      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         case (setting)
            0: begin
               lo = 15'd19200;
               hi = 15'd23025;
            end
            1: begin
               lo = 15'd0;
               hi = HUE_TURN;
            end
            2: begin
               lo = 15'd0;
               hi = 15'h7FFF;
            end
            3: begin
               lo = 15'd22400;
               hi = 15'd18560;
            end
            4: begin
               lo = 15'd100;
               hi = 15'd101;
            end
            5: begin
               lo = 15'h7FFF;
               hi = 15'h7FFF;
            end
            6: begin
               lo = 15'd0;
               hi = 15'd0;
            end
            7: begin
               lo = HUE_TURN;
               hi = 15'd0;
            end
            default: begin
               lo = HUE_W'($urandom_range(0, HUE_TURN));
               hi = HUE_W'($urandom_range(lo, HUE_TURN));
            end
         endcase
         calm = (setting % 4 == 3);
         write_bounds(lo, hi);
         if (setting == 0)
            foreach (BOUND_PIXELS[i]) send_pixel(BOUND_PIXELS[i]);
         repeat (PIXELS_PER_SETTING) send_pixel(random_pixel());
         req_valid <= 1'b0;
         drain();
      end

      // Leave room for any stray result word to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d of %0d pixels over %0d hue window settings, %0d of them keyed.",
               checked_count, pixels_sent, SETTING_COUNT + 1, keyed_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("hue_window_chroma_key test passed");
      end else begin
         $display("hue_window_chroma_key test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("Timed out with %0d result words outstanding.", pending_count);
      $display("hue_window_chroma_key test failed");
      $finish;
   end

endmodule
